/* hdl/gnva_pkg.sv */
`timescale 1ns / 1ps
// Package for the grid neighbour velocity averaging block.
// Field widths, command codes and size defaults; no dependencies.
package gnva_pkg;

  localparam int VEL_W    = 32;
  localparam int SUM_W    = 35;
  localparam int COORD_W  = 4;
  localparam int CFG_W    = 5;
  localparam int SIZE_W   = 7;
  localparam int CNT_W    = 3;
  localparam int MAX_SIZE = 16;
  localparam int SIZE_RST = 16;

  localparam int S_TDATA_W = 112;
  localparam int M_TDATA_W = 104;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_COMPUTE = 2'd1,
    CMD_COMMIT  = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_e;

  typedef logic [2:0][SUM_W-1:0] sum_vec_t;
  typedef logic [2:0][VEL_W-1:0] vel_vec_t;

endpackage

/* hdl/grid_neighbour_velocity_average.sv */
`timescale 1ns / 1ps
// Top level: 3D velocity grid with current/next banks and six-point averaging.
// Depends on gnva_pkg and gnva_mean_div.
//
// One command at a time; s_axis_tready is high only while idle. After reset the
// block clears both banks, one node per cycle, all MAX_SIZE_X*MAX_SIZE_Y*MAX_SIZE_Z
// nodes (4096 by default), before taking the first transfer. Compute reads each
// in-range neighbour through the single bank read port and skips missing ones,
// then divides in the bit-serial divider (no division for a lone node).
// Out-of-range coordinates go straight to the result. Commit copies the next bank
// into the current bank, one node copied per cycle.
module grid_neighbour_velocity_average import gnva_pkg::*; #(
  parameter int MAX_SIZE_X = MAX_SIZE,
  parameter int MAX_SIZE_Y = MAX_SIZE,
  parameter int MAX_SIZE_Z = MAX_SIZE
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // coord_x, coord_y, coord_z, in_vel_x, in_vel_y, in_vel_z, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // cmd
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // neighbour_count, out_vel_x, out_vel_y, out_vel_z, zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic                 m_axis_tuser
);

  localparam int DEPTH = MAX_SIZE_X * MAX_SIZE_Y * MAX_SIZE_Z;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int MEM_W = 3 * VEL_W;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_DISP   = 10'b0000000100,
    ST_COPY   = 10'b0000001000,
    ST_RDWAIT = 10'b0000010000,
    ST_NSEL   = 10'b0000100000,
    ST_NACC   = 10'b0001000000,
    ST_DSTART = 10'b0010000000,
    ST_DWAIT  = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_e;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [CFG_W-1:0] v, int mx);
    logic [SIZE_W-1:0] r;
    if (v == '0) r = SIZE_W'(1);
    else if (int'(v) > mx) r = SIZE_W'(mx);
    else r = SIZE_W'(v);
    return r;
  endfunction

  function automatic logic [AW-1:0] node_addr(logic [COORD_W:0] x, logic [COORD_W:0] y,
                                               logic [COORD_W:0] z);
    return AW'(int'(z) + int'(y) * MAX_SIZE_Z + int'(x) * (MAX_SIZE_Y * MAX_SIZE_Z));
  endfunction

  state_e state_q, state_d;
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [CW-1:0]     cnt_q, cnt_d, cnt_m1;
  logic [2:0]        k_q, k_d;
  logic [CNT_W-1:0]  nb_q, nb_d;
  cmd_e              cmd_q;
  logic [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic [MEM_W-1:0]  wvel_q;
  sum_vec_t          sum_q, sum_d;
  logic              res_st_q, res_st_d;
  logic [CNT_W-1:0]  res_nb_q, res_nb_d;
  vel_vec_t          res_vel_q, res_vel_d;
  logic              ov_q, ov_d;
  logic [M_TDATA_W-1:0] otd_q, otd_d;
  logic              ous_q, ous_d;

  logic [MEM_W-1:0] cur_mem [DEPTH];
  logic [MEM_W-1:0] nxt_mem [DEPTH];
  logic [MEM_W-1:0] cur_rd_q, nxt_rd_q, cur_wd, nxt_wd;
  logic [AW-1:0]    cur_ra, nxt_ra, cur_wa, nxt_wa;
  logic             cur_we, nxt_we;

  logic [COORD_W:0] ex, ey, ez;
  logic             oob, nb_ok;
  logic [AW-1:0]    self_a, nb_a;
  logic             div_start, div_done;
  vel_vec_t         div_mean;

  assign ex = {1'b0, cx_q};
  assign ey = {1'b0, cy_q};
  assign ez = {1'b0, cz_q};
  assign oob = ({3'b0, cx_q} >= size_x_q) || ({3'b0, cy_q} >= size_y_q) ||
               ({3'b0, cz_q} >= size_z_q);
  assign self_a = node_addr(ex, ey, ez);
  assign cnt_m1 = cnt_q - 1'b1;

  always_comb begin
    nb_ok = 1'b0;
    nb_a  = self_a;
    case (k_q)
      3'd0: begin nb_ok = cx_q != '0;                   nb_a = node_addr(ex - 1'b1, ey, ez); end
      3'd1: begin nb_ok = {2'b0, ex} + 1'b1 < size_x_q; nb_a = node_addr(ex + 1'b1, ey, ez); end
      3'd2: begin nb_ok = cy_q != '0;                   nb_a = node_addr(ex, ey - 1'b1, ez); end
      3'd3: begin nb_ok = {2'b0, ey} + 1'b1 < size_y_q; nb_a = node_addr(ex, ey + 1'b1, ez); end
      3'd4: begin nb_ok = cz_q != '0;                   nb_a = node_addr(ex, ey, ez - 1'b1); end
      3'd5: begin nb_ok = {2'b0, ez} + 1'b1 < size_z_q; nb_a = node_addr(ex, ey, ez + 1'b1); end
      default: nb_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    nb_d      = nb_q;
    sum_d     = sum_q;
    res_st_d  = res_st_q;
    res_nb_d  = res_nb_q;
    res_vel_d = res_vel_q;
    ov_d      = ov_q;
    otd_d     = otd_q;
    ous_d     = ous_q;
    cur_we    = 1'b0;
    nxt_we    = 1'b0;
    cur_wa    = self_a;
    nxt_wa    = self_a;
    cur_wd    = wvel_q;
    nxt_wd    = wvel_q;
    cur_ra    = self_a;
    nxt_ra    = cnt_q[AW-1:0];
    div_start = 1'b0;

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        cur_we = 1'b1;
        nxt_we = 1'b1;
        cur_wa = cnt_q[AW-1:0];
        nxt_wa = cnt_q[AW-1:0];
        cur_wd = '0;
        nxt_wd = '0;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CW'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_DISP;
      end
      ST_DISP: begin
        res_st_d  = 1'b0;
        res_nb_d  = '0;
        res_vel_d = '0;
        sum_d     = '0;
        nb_d      = '0;
        k_d       = '0;
        cnt_d     = '0;
        if (cmd_q == CMD_COMMIT) begin
          state_d = ST_COPY;
        end else if (oob) begin
          res_st_d = 1'b1;
          state_d  = ST_DONE;
        end else begin
          case (cmd_q)
            CMD_WRITE: begin
              cur_we  = 1'b1;
              nxt_we  = 1'b1;
              state_d = ST_DONE;
            end
            CMD_READ:    state_d = ST_RDWAIT;
            CMD_COMPUTE: state_d = ST_NSEL;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_COPY: begin
        cnt_d  = cnt_q + 1'b1;
        cur_we = cnt_q != '0;
        cur_wa = cnt_m1[AW-1:0];
        cur_wd = nxt_rd_q;
        if (cnt_q == CW'(DEPTH)) state_d = ST_DONE;
      end
      ST_RDWAIT: begin
        res_vel_d = cur_rd_q;
        state_d   = ST_DONE;
      end
      ST_NSEL: begin
        cur_ra = nb_a;
        if (nb_ok) begin
          state_d = ST_NACC;
        end else begin
          k_d = k_q + 1'b1;
          if (k_q == 3'd5) state_d = ST_DSTART;
        end
      end
      ST_NACC: begin
        for (int c = 0; c < 3; c++) begin
          sum_d[c] = sum_q[c] + {{(SUM_W-VEL_W){cur_rd_q[c*VEL_W+VEL_W-1]}},
                                 cur_rd_q[c*VEL_W +: VEL_W]};
        end
        nb_d = nb_q + 1'b1;
        k_d  = k_q + 1'b1;
        state_d = (k_q == 3'd5) ? ST_DSTART : ST_NSEL;
      end
      ST_DSTART: begin
        res_nb_d = nb_q;
        if (nb_q == '0) begin
          nxt_we  = 1'b1;
          nxt_wd  = '0;
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        if (div_done) begin
          nxt_we    = 1'b1;
          nxt_wd    = div_mean;
          res_vel_d = div_mean;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d  = 1'b1;
          ous_d = res_st_q;
          otd_d = {5'b0, res_vel_q, res_nb_q};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      k_q      <= '0;
      nb_q     <= '0;
      ov_q     <= 1'b0;
      size_x_q <= clamp_size(CFG_W'(SIZE_RST), MAX_SIZE_X);
      size_y_q <= clamp_size(CFG_W'(SIZE_RST), MAX_SIZE_Y);
      size_z_q <= clamp_size(CFG_W'(SIZE_RST), MAX_SIZE_Z);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      nb_q    <= nb_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SIZE_X: size_x_q <= clamp_size(cfg_data_i, MAX_SIZE_X);
          REG_SIZE_Y: size_y_q <= clamp_size(cfg_data_i, MAX_SIZE_Y);
          REG_SIZE_Z: size_z_q <= clamp_size(cfg_data_i, MAX_SIZE_Z);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q  <= cmd_e'(s_axis_tuser);
      cx_q   <= s_axis_tdata[3:0];
      cy_q   <= s_axis_tdata[7:4];
      cz_q   <= s_axis_tdata[11:8];
      wvel_q <= s_axis_tdata[107:12];
    end
    sum_q     <= sum_d;
    res_st_q  <= res_st_d;
    res_nb_q  <= res_nb_d;
    res_vel_q <= res_vel_d;
    otd_q     <= otd_d;
    ous_q     <= ous_d;
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    cur_rd_q <= cur_mem[cur_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd_q <= nxt_mem[nxt_ra];
  end

  gnva_mean_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .count_i (nb_q),
    .sum_i   (sum_q),
    .done_o  (div_done),
    .mean_o  (div_mean)
  );

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = otd_q;
  assign m_axis_tuser  = ous_q;

endmodule

/* hdl/gnva_mean_div.sv */
`timescale 1ns / 1ps
// Iterative signed divider: three sums by a small count, one quotient bit per cycle.
// Depends on gnva_pkg.
module gnva_mean_div import gnva_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] count_i,
  input  sum_vec_t         sum_i,
  output logic             done_o,
  output vel_vec_t         mean_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  sum_vec_t              mag_q, mag_d;
  logic [2:0][CNT_W-1:0] rem_q, rem_d;
  logic [2:0]            neg_q, neg_d;
  logic [CNT_W-1:0]      div_q, div_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [2:0][CNT_W:0]   trial;
  logic [2:0]            ge;

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    div_d  = div_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_q[c], mag_q[c][SUM_W-1]};
      ge[c]    = trial[c] >= {1'b0, div_q};
    end
    if (start_i) begin
      for (int c = 0; c < 3; c++) begin
        neg_d[c] = sum_i[c][SUM_W-1];
        mag_d[c] = sum_i[c][SUM_W-1] ? (~sum_i[c] + 1'b1) : sum_i[c];
      end
      rem_d  = '0;
      div_d  = count_i;
      step_d = STEP_W'(SUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int c = 0; c < 3; c++) begin
        rem_d[c] = ge[c] ? CNT_W'(trial[c] - {1'b0, div_q}) : trial[c][CNT_W-1:0];
        mag_d[c] = {mag_q[c][SUM_W-2:0], ge[c]};
      end
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    div_q <= div_d;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mean_o[c] = neg_q[c] ? VEL_W'(~mag_q[c] + 1'b1) : mag_q[c][VEL_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

/* hdl/gnva_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the grid averaging top level, with its bind.
// Depends on gnva_pkg.
module gnva_port_assert import gnva_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transfer taken while busy");

  a_bad_coord_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("out-of-range result carries data");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7)
    else $error("neighbour count above six");

endmodule

bind grid_neighbour_velocity_average gnva_port_assert u_gnva_port_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* dv/gnva_checker.sv */
`timescale 1ns / 1ps
// Checker for grid_neighbour_velocity_average: follows size register writes and
// command transfers, predicts each result from its own copy of both velocity banks,
// and compares it with the result transfers. Depends on gnva_pkg.
module gnva_checker import gnva_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 m_axis_tuser,
  output int                   fails_o,
  output int                   pending_o
);

  localparam int NODES = MAX_SIZE * MAX_SIZE * MAX_SIZE;

  // same bit order as {tuser, tdata[98:0]}
  typedef struct packed {
    logic             status;
    logic [VEL_W-1:0] vz;
    logic [VEL_W-1:0] vy;
    logic [VEL_W-1:0] vx;
    logic [CNT_W-1:0] count;
  } node_result_t;

  logic [VEL_W-1:0] cur_x [NODES];
  logic [VEL_W-1:0] cur_y [NODES];
  logic [VEL_W-1:0] cur_z [NODES];
  logic [VEL_W-1:0] nxt_x [NODES];
  logic [VEL_W-1:0] nxt_y [NODES];
  logic [VEL_W-1:0] nxt_z [NODES];
  int unsigned      grid_size [3];
  node_result_t     pending_results [$];

  function automatic int unsigned node_at(int unsigned x, int unsigned y, int unsigned z);
    return z + y * MAX_SIZE + x * MAX_SIZE * MAX_SIZE;
  endfunction

  function automatic int unsigned clamp_size(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIZE) return MAX_SIZE;
    return v;
  endfunction

  function automatic node_result_t predict_node_result(cmd_e cmd, logic [S_TDATA_W-1:0] d);
    node_result_t r;
    int unsigned  x, y, z, i, n;
    longint       sx, sy, sz;
    int unsigned  nb [6];
    r = '0;
    x = d[3:0];
    y = d[7:4];
    z = d[11:8];
    sx = 0;
    sy = 0;
    sz = 0;
    n = 0;
    if (cmd == CMD_COMMIT) begin
      cur_x = nxt_x;
      cur_y = nxt_y;
      cur_z = nxt_z;
      return r;
    end
    if (x >= grid_size[0] || y >= grid_size[1] || z >= grid_size[2]) begin
      r.status = 1'b1;
      return r;
    end
    i = node_at(x, y, z);
    case (cmd)
      CMD_WRITE: begin
        cur_x[i] = d[43:12];
        cur_y[i] = d[75:44];
        cur_z[i] = d[107:76];
        nxt_x[i] = d[43:12];
        nxt_y[i] = d[75:44];
        nxt_z[i] = d[107:76];
      end
      CMD_READ: begin
        r.vx = cur_x[i];
        r.vy = cur_y[i];
        r.vz = cur_z[i];
      end
      default: begin
        if (x > 0) begin nb[n] = node_at(x - 1, y, z); n++; end
        if (x + 1 < grid_size[0]) begin nb[n] = node_at(x + 1, y, z); n++; end
        if (y > 0) begin nb[n] = node_at(x, y - 1, z); n++; end
        if (y + 1 < grid_size[1]) begin nb[n] = node_at(x, y + 1, z); n++; end
        if (z > 0) begin nb[n] = node_at(x, y, z - 1); n++; end
        if (z + 1 < grid_size[2]) begin nb[n] = node_at(x, y, z + 1); n++; end
        for (int k = 0; k < int'(n); k++) begin
          sx += longint'($signed(cur_x[nb[k]]));
          sy += longint'($signed(cur_y[nb[k]]));
          sz += longint'($signed(cur_z[nb[k]]));
        end
        if (n > 0) begin
          sx = sx / longint'(n);
          sy = sy / longint'(n);
          sz = sz / longint'(n);
        end
        r.count = CNT_W'(n);
        r.vx = sx[31:0];
        r.vy = sy[31:0];
        r.vz = sz[31:0];
        nxt_x[i] = r.vx;
        nxt_y[i] = r.vy;
        nxt_z[i] = r.vz;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    node_result_t want, got, pred;
    if (!rst_ni) begin
      grid_size = '{SIZE_RST, SIZE_RST, SIZE_RST};
      for (int i = 0; i < NODES; i++) begin
        cur_x[i] = '0;
        cur_y[i] = '0;
        cur_z[i] = '0;
        nxt_x[i] = '0;
        nxt_y[i] = '0;
        nxt_z[i] = '0;
      end
      pending_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[98:0]};
        if (pending_results.size() == 0) begin
          fails_o++;
          if (fails_o <= 10) $display("%0t: result with none pending: %h", $realtime, got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fails_o++;
            if (fails_o <= 10)
              $display("%0t: mismatch st %0d/%0d cnt %0d/%0d vel %h %h %h / %h %h %h",
                       $realtime, want.status, got.status, want.count, got.count,
                       want.vx, want.vy, want.vz, got.vx, got.vy, got.vz);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = predict_node_result(cmd_e'(s_axis_tuser), s_axis_tdata);
        pending_results = {pending_results, pred};
      end
      if (cfg_we_i && cfg_idx_i <= REG_SIZE_Z)
        grid_size[cfg_idx_i] = clamp_size(cfg_data_i);
    end
    pending_o = pending_results.size();
  end

endmodule

/* dv/tb_grid_neighbour_velocity_average.sv */
`timescale 1ns / 1ps
// Testbench top for grid_neighbour_velocity_average: drives commands and size writes,
// random stalls on both sides, and gives the verdict. Depends on gnva_pkg, gnva_checker.
module tb_grid_neighbour_velocity_average;
  import gnva_pkg::*;

  localparam int IDLE_LIMIT = 40000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [1:0]           cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [1:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  int                   fails;
  int                   pending;
  int unsigned          grid_size [3];
  bit                   quiet;
  bit                   hold_req;
  int                   idle_cycles = 0;

  grid_neighbour_velocity_average u_dut (.*);

  gnva_checker u_checker (.*, .fails_o(fails), .pending_o(pending));

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("grid_neighbour_velocity_average test failed");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  task automatic send(cmd_e cmd, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                      logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, vz, vy, vx, z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_sizes(logic [CFG_W-1:0] sx, logic [CFG_W-1:0] sy, logic [CFG_W-1:0] sz);
    logic [CFG_W-1:0] v [3];
    v = '{sx, sy, sz};
    for (int r = 0; r < 3; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_e'(r);
      cfg_data_i <= v[r];
      grid_size[r] = (v[r] == 0) ? 1 : (v[r] > MAX_SIZE ? MAX_SIZE : v[r]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] rand_coord(int axis);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, grid_size[axis] - 1);
    return $urandom_range(0, 15);
  endfunction

  task automatic send_random(int n);
    int   p;
    cmd_e c;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      c = p < 2 ? CMD_COMMIT : p < 40 ? CMD_WRITE : p < 70 ? CMD_COMPUTE : CMD_READ;
      send(c, rand_coord(0), rand_coord(1), rand_coord(2), rand_vel(), rand_vel(), rand_vel());
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_SIZE_X;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_WRITE;
    quiet = 1'b0;
    hold_req = 1'b0;
    grid_size = '{SIZE_RST, SIZE_RST, SIZE_RST};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners, extreme values, averaging over a full neighbourhood
    send(CMD_WRITE, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send(CMD_WRITE, 15, 15, 15, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send(CMD_WRITE, 1, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0003);
    send(CMD_WRITE, 0, 1, 0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_fffe);
    send(CMD_WRITE, 0, 0, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send(CMD_COMPUTE, 0, 0, 0, 0, 0, 0);
    send(CMD_COMPUTE, 1, 1, 1, 0, 0, 0);
    send(CMD_COMPUTE, 15, 15, 15, 0, 0, 0);
    send(CMD_READ, 0, 0, 0, 0, 0, 0);
    send(CMD_COMMIT, 0, 0, 0, 0, 0, 0);
    send(CMD_READ, 0, 0, 0, 0, 0, 0);
    send(CMD_READ, 15, 15, 15, 0, 0, 0);
    wait_idle();

    // all sizes zero act as one: lone node, out-of-range coordinates
    set_sizes(0, 0, 0);
    send(CMD_WRITE, 0, 0, 0, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f);
    send(CMD_COMPUTE, 0, 0, 0, 0, 0, 0);
    send(CMD_WRITE, 1, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(CMD_COMPUTE, 0, 15, 0, 0, 0, 0);
    send(CMD_READ, 0, 0, 15, 0, 0, 0);
    send(CMD_READ, 0, 0, 0, 0, 0, 0);
    send(CMD_COMMIT, 0, 0, 0, 0, 0, 0);
    send(CMD_READ, 0, 0, 0, 0, 0, 0);
    send_random(40);
    wait_idle();

    // values above the maximum clamp
    set_sizes(31, 17, 16);
    fork
      begin
        repeat (30) @(posedge clk_i);
        hold_req = 1'b1;
      end
      send_random(130);
    join
    wait_idle();

    set_sizes(3, 2, 4);
    send_random(140);
    wait_idle();

    set_sizes(2, 16, 1);
    send_random(110);
    wait_idle();

    set_sizes(1, 5, 16);
    send_random(100);
    wait_idle();

    quiet = 1'b1;
    set_sizes(4, 3, 3);
    send_random(130);
    s_axis_tvalid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);
    if (fails == 0 && pending == 0) $display("grid_neighbour_velocity_average test passed");
    else $display("grid_neighbour_velocity_average test failed");
    $finish;
  end

endmodule
